FILE: sv/aam_pkg.sv
// Package for the atomic accumulate memory: request and response types,
// operation, reduce-operator, status and register codes. No dependencies.
`default_nettype none

package aam_pkg;

    // Default geometry of the shared store.
    localparam int NUM_UNITS_DEF     = 8;
    localparam int SEGMENT_DEPTH_DEF = 1024;

    // Configuration port widths and register codes.
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_SIZE = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_POOL_SEG   = 4'd1;
    localparam logic [10:0] LOCAL_SIZE_RST = 11'd1024;
    localparam logic [7:0]  POOL_SEG_RST   = 8'd0;

    // Operation codes.
    localparam logic [1:0] OP_GET = 2'd0;
    localparam logic [1:0] OP_PUT = 2'd1;
    localparam logic [1:0] OP_ACC = 2'd2;
    localparam logic [1:0] OP_BAD = 2'd3;

    // Reduce operator codes.
    localparam logic [3:0] ROP_MIN  = 4'd0;
    localparam logic [3:0] ROP_MAX  = 4'd1;
    localparam logic [3:0] ROP_SUM  = 4'd2;
    localparam logic [3:0] ROP_PROD = 4'd3;
    localparam logic [3:0] ROP_BAND = 4'd4;
    localparam logic [3:0] ROP_LAND = 4'd5;
    localparam logic [3:0] ROP_BOR  = 4'd6;
    localparam logic [3:0] ROP_LOR  = 4'd7;
    localparam logic [3:0] ROP_BXOR = 4'd8;
    localparam logic [3:0] ROP_LXOR = 4'd9;

    // Data type code for a 32-bit integer.
    localparam logic [3:0] DTYPE_INT32 = 4'd0;

    // Status codes.
    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_BAD_TYPE = 3'd1;
    localparam logic [2:0] STAT_BAD_SEG  = 3'd2;
    localparam logic [2:0] STAT_RANGE    = 3'd3;
    localparam logic [2:0] STAT_BAD_OP   = 3'd4;

    // One request.
    typedef struct packed {
        logic [1:0]         operation;
        logic [2:0]         target_unit;
        logic [9:0]         element_offset;
        logic [7:0]         segment_id;
        logic [3:0]         data_type;
        logic [3:0]         reduce_op;
        logic signed [31:0] data_value;
        logic               final_element;
    } req_t;

    // One response.
    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] read_data;
        logic               request_done;
    } rsp_t;

endpackage

`default_nettype wire

FILE: sv/atomic_accumulate_memory.sv
// Atomic accumulate memory: a shared word store with get, put and
// read-modify-write reduce operations. Depends on aam_pkg.
//
// Usage:
//   Requests enter on s_valid/s_ready/s_data, responses leave on
//   m_valid/m_ready/m_data, one response per request, in order.
//   Registers are written on cfg_valid/cfg_index/cfg_data; cfg_ready is
//   always high and writes are taken at any time, including during the
//   clearing pass.
//   An accepted request waits in the second stage until the response register
//   is free. One request per cycle while the output does not stall. The store
//   has one read and one write port; the read is issued at acceptance, the
//   write-back happens as the request leaves the second stage, and a write-back
//   register forwards the newest word if the next request has the same address.
//   Reset: aresetn (synchronous, active low) restores the registers and then
//   a clearing pass writes zero to all NUM_UNITS * SEGMENT_DEPTH words (8192
//   with the defaults), one word per cycle. s_ready stays low until the pass
//   is done.
//   Stall: while m_ready is low a valid response holds, the request in
//   flight waits in the second stage, and s_ready falls once that stage is
//   occupied.
`default_nettype none

module atomic_accumulate_memory #(
    parameter int NUM_UNITS     = aam_pkg::NUM_UNITS_DEF,
    parameter int SEGMENT_DEPTH = aam_pkg::SEGMENT_DEPTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire aam_pkg::req_t                s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output aam_pkg::rsp_t                     m_data,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [aam_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [aam_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import aam_pkg::*;

    localparam int STORE_WORDS = NUM_UNITS * SEGMENT_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int PROD_W      = 15;
    localparam int AW_EXT      = (ADDR_W > PROD_W) ? ADDR_W : PROD_W;

    // Configuration registers.
    logic [10:0] local_size_reg;
    logic [7:0]  pool_seg_reg;

    // Clearing pass.
    logic              clr_busy_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    // Second stage.
    logic              b_valid_reg;
    logic [ADDR_W-1:0] b_addr_reg;
    logic [1:0]        b_op_reg;
    logic [3:0]        b_rop_reg;
    logic [31:0]       b_val_reg;
    logic [2:0]        b_status_reg;
    logic              b_fin_reg;

    // Write-back forwarding.
    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [31:0]       fwd_data_reg;

    // Store and its registered read data.
    logic [31:0] mem [STORE_WORDS];
    logic [31:0] rd_data_reg;

    // Response register.
    logic  m_valid_reg;
    rsp_t  m_data_reg;

    logic              s_fire;
    logic              b_go;
    logic [10:0]       size_use;
    logic              unit_ok;
    logic              offs_ok;
    logic [2:0]        a_status;
    logic [AW_EXT-1:0] a_addr_ext;
    logic [ADDR_W-1:0] a_addr;
    logic [31:0]       old_word;
    logic [31:0]       red_word;
    logic              red_bad;
    logic              a_nz;
    logic              b_nz;
    logic [31:0]       b_write_data;
    logic              b_write;
    rsp_t              b_rsp;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [31:0]       mem_wdata;

    assign cfg_ready = 1'b1;
    assign b_go      = b_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !clr_busy_reg && (!b_valid_reg || b_go);
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_size_reg <= LOCAL_SIZE_RST;
            pool_seg_reg   <= POOL_SEG_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_LOCAL_SIZE: local_size_reg <= cfg_data[10:0];
                CFG_POOL_SEG:   pool_seg_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Request checks and word address in the first stage.
    always_comb begin
        if (32'(local_size_reg) > 32'(SEGMENT_DEPTH)) begin
            size_use = 11'(SEGMENT_DEPTH);
        end else begin
            size_use = local_size_reg;
        end
        unit_ok = 32'(s_data.target_unit) < 32'(NUM_UNITS);
        offs_ok = {1'b0, s_data.element_offset} < size_use;
        if (s_data.operation == OP_BAD) begin
            a_status = STAT_BAD_OP;
        end else if (s_data.operation == OP_ACC && s_data.data_type != DTYPE_INT32) begin
            a_status = STAT_BAD_TYPE;
        end else if (s_data.segment_id != pool_seg_reg) begin
            a_status = STAT_BAD_SEG;
        end else if (!unit_ok || !offs_ok) begin
            a_status = STAT_RANGE;
        end else begin
            a_status = STAT_OK;
        end
        a_addr_ext = AW_EXT'(s_data.target_unit) * AW_EXT'(size_use)
                   + AW_EXT'(s_data.element_offset);
        a_addr     = a_addr_ext[ADDR_W-1:0];
    end

    // Second-stage registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (s_fire) begin
            b_valid_reg <= 1'b1;
        end else if (b_go) begin
            b_valid_reg <= 1'b0;
        end
        if (s_fire) begin
            b_addr_reg   <= a_addr;
            b_op_reg     <= s_data.operation;
            b_rop_reg    <= s_data.reduce_op;
            b_val_reg    <= s_data.data_value;
            b_status_reg <= a_status;
            b_fin_reg    <= s_data.final_element;
        end
    end

    // Current word: forwarded from the last write-back when addresses match.
    assign old_word = (fwd_valid_reg && fwd_addr_reg == b_addr_reg) ? fwd_data_reg
                                                                    : rd_data_reg;
    assign a_nz = old_word != 32'd0;
    assign b_nz = b_val_reg != 32'd0;

    // Reduce operator.
    always_comb begin
        red_bad = 1'b0;
        case (b_rop_reg)
            ROP_MIN:  red_word = ($signed(old_word) < $signed(b_val_reg)) ? old_word
                                                                          : b_val_reg;
            ROP_MAX:  red_word = ($signed(b_val_reg) < $signed(old_word)) ? old_word
                                                                          : b_val_reg;
            ROP_SUM:  red_word = old_word + b_val_reg;
            ROP_PROD: red_word = old_word * b_val_reg;
            ROP_BAND: red_word = old_word & b_val_reg;
            ROP_LAND: red_word = {31'd0, a_nz && b_nz};
            ROP_BOR:  red_word = old_word | b_val_reg;
            ROP_LOR:  red_word = {31'd0, a_nz || b_nz};
            ROP_BXOR: red_word = old_word ^ b_val_reg;
            ROP_LXOR: red_word = {31'd0, a_nz != b_nz};
            default: begin
                red_word = 32'd0;
                red_bad  = 1'b1;
            end
        endcase
    end

    // Response and write-back of the second stage.
    always_comb begin
        b_write             = 1'b0;
        b_write_data        = red_word;
        b_rsp.status        = b_status_reg;
        b_rsp.read_data     = '0;
        b_rsp.request_done  = b_fin_reg;
        if (b_status_reg == STAT_OK) begin
            case (b_op_reg)
                OP_GET: b_rsp.read_data = old_word;
                OP_PUT: begin
                    b_write      = 1'b1;
                    b_write_data = b_val_reg;
                end
                OP_ACC: begin
                    b_write         = 1'b1;
                    b_rsp.read_data = red_word;
                    if (red_bad) begin
                        b_rsp.status = STAT_BAD_OP;
                    end
                end
                default: ;
            endcase
        end
    end

    // Write port: the clearing pass or the second stage.
    assign mem_we    = clr_busy_reg || (b_go && b_write);
    assign mem_waddr = clr_busy_reg ? clr_addr_reg : b_addr_reg;
    assign mem_wdata = clr_busy_reg ? 32'd0 : b_write_data;

    // Clearing pass after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(STORE_WORDS - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Store: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (s_fire) begin
            rd_data_reg <= mem[a_addr];
        end
    end

    // Forwarding register follows the newest write-back.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (b_go && b_write) begin
            fwd_valid_reg <= 1'b1;
        end
        if (b_go && b_write) begin
            fwd_addr_reg <= b_addr_reg;
            fwd_data_reg <= b_write_data;
        end
    end

    // Response register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (b_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (b_go) begin
            m_data_reg <= b_rsp;
        end
    end

endmodule

`default_nettype wire

FILE: sv/aam_checker.sv
// Port-level checks for the atomic accumulate memory, bound to the top level.
// Depends on aam_pkg and atomic_accumulate_memory.
`default_nettype none

module aam_checker (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    input  wire logic          s_ready,
    input  wire logic          m_valid,
    input  wire logic          m_ready,
    input  wire aam_pkg::rsp_t m_data
);
    import aam_pkg::*;

    // The clearing pass holds off requests right after reset.
    a_reset_blocks: assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("request taken right after reset");

    // A stalled response holds.
    a_rsp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled response changed");

    // A rejected request returns zero data.
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != STAT_OK) |-> (m_data.read_data == 32'sd0))
        else $error("rejected request returned data");

    // A status is one of the defined codes.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == STAT_OK || m_data.status == STAT_BAD_TYPE ||
                     m_data.status == STAT_BAD_SEG || m_data.status == STAT_RANGE ||
                     m_data.status == STAT_BAD_OP))
        else $error("undefined status code");

    // A response that appears after an idle output follows an accepted request.
    a_rsp_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("response without a request");

endmodule

bind atomic_accumulate_memory aam_checker u_aam_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
